/* rtl/core/ivg_pkg.sv */
// shared types, constants and vertex tables of the icosphere vertex generator
package ivg_pkg;

    localparam int MAX_DETAIL = 64;
    localparam int DW         = 7;
    localparam int VW         = 18;
    localparam int CW         = 10;
    localparam int PW         = 28;
    localparam int NW         = 2 * PW;
    localparam int SW         = PW;
    localparam int QW         = 15;
    localparam int FRAC       = 14;
    localparam int DNW        = PW + FRAC + 1;
    localparam int OW         = 16;
    localparam int IDXW       = 16;
    localparam int SQ_STAGES  = NW / 2;
    localparam int Q_ONE      = 65536;
    localparam int Q_PHI      = 106040;
    localparam int OUT_ONE    = 16384;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
    } vtx_t;

    typedef struct packed {
        logic [IDXW-1:0]      idx;
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic signed [PW-1:0] pz;
    } tag_t;

    typedef struct packed {
        tag_t          tag;
        logic [NW-1:0] rem;
        logic [NW-1:0] res;
    } sq_t;

    typedef struct packed {
        logic [IDXW-1:0]          idx;
        logic [2:0]               neg;
        logic                     zero;
        logic [SW-1:0]            s;
        logic [2:0][DNW-1:0]      num;
        logic [2:0][QW-1:0]       q;
    } dv_t;

    function automatic vtx_t mk_vtx(input int x, input int y, input int z);
        vtx_t v;
        v.x = VW'(x);
        v.y = VW'(y);
        v.z = VW'(z);
        return v;
    endfunction

    function automatic vtx_t north_pole();
        return mk_vtx(0, Q_ONE, Q_PHI);
    endfunction

    function automatic vtx_t south_pole();
        return mk_vtx(0, -Q_ONE, -Q_PHI);
    endfunction

    function automatic vtx_t north_ring(input logic [2:0] i);
        vtx_t v;
        case (i)
            3'd0:    v = mk_vtx(0, -Q_ONE, Q_PHI);
            3'd1:    v = mk_vtx(Q_PHI, 0, Q_ONE);
            3'd2:    v = mk_vtx(Q_ONE, Q_PHI, 0);
            3'd3:    v = mk_vtx(-Q_ONE, Q_PHI, 0);
            3'd4:    v = mk_vtx(-Q_PHI, 0, Q_ONE);
            default: v = mk_vtx(0, 0, 0);
        endcase
        return v;
    endfunction

    function automatic vtx_t south_ring(input logic [2:0] i);
        vtx_t v;
        case (i)
            3'd0:    v = mk_vtx(-Q_ONE, -Q_PHI, 0);
            3'd1:    v = mk_vtx(Q_ONE, -Q_PHI, 0);
            3'd2:    v = mk_vtx(Q_PHI, 0, -Q_ONE);
            3'd3:    v = mk_vtx(0, Q_ONE, -Q_PHI);
            3'd4:    v = mk_vtx(-Q_PHI, 0, -Q_ONE);
            default: v = mk_vtx(0, 0, 0);
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/ivg_front.sv */
// face decode, interpolation and squared length
module ivg_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [ivg_pkg::DW-1:0]    detail,
    input  logic                      in_valid,
    input  logic [2:0]                strip_sel,
    input  logic [6:0]                grid_column,
    input  logic [7:0]                grid_row,
    output logic                      sq_valid,
    output ivg_pkg::sq_t              sq_item
);

    // stage 1 decode
    logic [6:0]              de;
    logic [2:0]              st;
    logic [2:0]              nx;
    logic [2:0]              fs;
    logic [2:0]              fn;
    logic [6:0]              fc;
    logic signed [9:0]       r10;
    logic signed [9:0]       d10;
    logic signed [9:0]       col10;
    logic signed [9:0]       c1;
    logic signed [9:0]       c2;
    ivg_pkg::vtx_t           v0;
    ivg_pkg::vtx_t           v1;
    ivg_pkg::vtx_t           v2;
    logic [9:0]              cs;
    logic [7:0]              dq;

    always_comb
    begin
        if (detail == '0)
            de = 7'd1;
        else if (detail > 7'(ivg_pkg::MAX_DETAIL))
            de = 7'(ivg_pkg::MAX_DETAIL);
        else
            de = detail;
        st = (strip_sel >= 3'd5) ? strip_sel - 3'd5 : strip_sel;
        nx = (st == 3'd4) ? 3'd0 : st + 3'd1;
        cs = {3'b0, grid_column} + 10'({3'b0, de} * {7'b0, st});
        dq = {1'b0, de} * 8'd3 + 8'd1;
        fs = st;
        fn = nx;
        fc = grid_column;
        if (({1'b0, grid_row} >= {1'b0, de, 1'b0}) && grid_column == 7'd0)
        begin
            fs = (st == 3'd0) ? 3'd4 : st - 3'd1;
            fn = st;
            fc = de;
        end
        r10   = $signed({2'b0, grid_row});
        d10   = $signed({3'b0, de});
        col10 = $signed({3'b0, fc});
        if (r10 <= d10)
        begin
            v0 = ivg_pkg::north_ring(fs);
            v1 = ivg_pkg::north_pole();
            v2 = ivg_pkg::north_ring(fn);
            c1 = d10 - r10;
            c2 = col10;
        end
        else if (r10 >= d10 + d10)
        begin
            v0 = ivg_pkg::south_ring(fn);
            v1 = ivg_pkg::south_pole();
            v2 = ivg_pkg::south_ring(fs);
            c1 = r10 - d10 - d10;
            c2 = d10 - col10;
        end
        else if (r10 <= d10 + col10)
        begin
            v0 = ivg_pkg::north_ring(fn);
            v1 = ivg_pkg::south_ring(fn);
            v2 = ivg_pkg::north_ring(fs);
            c1 = r10 - d10;
            c2 = d10 - col10;
        end
        else
        begin
            v0 = ivg_pkg::south_ring(fs);
            v1 = ivg_pkg::south_ring(fn);
            v2 = ivg_pkg::north_ring(fs);
            c1 = col10;
            c2 = d10 + d10 - r10;
        end
    end

    logic                    v1_reg;
    logic signed [7:0]       d_reg;
    ivg_pkg::vtx_t           v0_reg;
    ivg_pkg::vtx_t           v1v_reg;
    ivg_pkg::vtx_t           v2_reg;
    logic signed [9:0]       c1_reg;
    logic signed [9:0]       c2_reg;
    logic [7:0]              row_reg;
    logic [7:0]              dq_reg;
    logic [9:0]              cs_reg;

    // stage 2 products
    logic signed [ivg_pkg::VW:0]   e1x, e1y, e1z, e2x, e2y, e2z;
    logic signed [ivg_pkg::PW-1:0] a0x_next, a0y_next, a0z_next;
    logic signed [ivg_pkg::PW-1:0] a1x_next, a1y_next, a1z_next;
    logic signed [ivg_pkg::PW-1:0] a2x_next, a2y_next, a2z_next;
    logic [17:0]                   iprod;
    logic [ivg_pkg::IDXW-1:0]      idx_next;

    always_comb
    begin
        e1x = {v1v_reg.x[ivg_pkg::VW-1], v1v_reg.x} - {v0_reg.x[ivg_pkg::VW-1], v0_reg.x};
        e1y = {v1v_reg.y[ivg_pkg::VW-1], v1v_reg.y} - {v0_reg.y[ivg_pkg::VW-1], v0_reg.y};
        e1z = {v1v_reg.z[ivg_pkg::VW-1], v1v_reg.z} - {v0_reg.z[ivg_pkg::VW-1], v0_reg.z};
        e2x = {v2_reg.x[ivg_pkg::VW-1], v2_reg.x} - {v0_reg.x[ivg_pkg::VW-1], v0_reg.x};
        e2y = {v2_reg.y[ivg_pkg::VW-1], v2_reg.y} - {v0_reg.y[ivg_pkg::VW-1], v0_reg.y};
        e2z = {v2_reg.z[ivg_pkg::VW-1], v2_reg.z} - {v0_reg.z[ivg_pkg::VW-1], v0_reg.z};
        a0x_next = d_reg * v0_reg.x;
        a0y_next = d_reg * v0_reg.y;
        a0z_next = d_reg * v0_reg.z;
        a1x_next = c1_reg * e1x;
        a1y_next = c1_reg * e1y;
        a1z_next = c1_reg * e1z;
        a2x_next = c2_reg * e2x;
        a2y_next = c2_reg * e2y;
        a2z_next = c2_reg * e2z;
        iprod    = {10'b0, dq_reg} * {8'b0, cs_reg};
        idx_next = ivg_pkg::IDXW'(iprod + {10'b0, row_reg});
    end

    logic                          v2v_reg;
    logic signed [ivg_pkg::PW-1:0] a0x_reg, a0y_reg, a0z_reg;
    logic signed [ivg_pkg::PW-1:0] a1x_reg, a1y_reg, a1z_reg;
    logic signed [ivg_pkg::PW-1:0] a2x_reg, a2y_reg, a2z_reg;
    logic [ivg_pkg::IDXW-1:0]      idx2_reg;

    // stage 3 sums
    logic                          v3_reg;
    ivg_pkg::tag_t                 tag3_reg;
    ivg_pkg::tag_t                 tag3_next;

    always_comb
    begin
        tag3_next.idx = idx2_reg;
        tag3_next.px  = a0x_reg + a1x_reg + a2x_reg;
        tag3_next.py  = a0y_reg + a1y_reg + a2y_reg;
        tag3_next.pz  = a0z_reg + a1z_reg + a2z_reg;
    end

    // stage 4 squares
    logic signed [ivg_pkg::NW-1:0] sqx_next, sqy_next, sqz_next;
    logic                          v4_reg;
    ivg_pkg::tag_t                 tag4_reg;
    logic [ivg_pkg::NW-1:0]        sqx_reg, sqy_reg, sqz_reg;

    always_comb
    begin
        sqx_next = tag3_reg.px * tag3_reg.px;
        sqy_next = tag3_reg.py * tag3_reg.py;
        sqz_next = tag3_reg.pz * tag3_reg.pz;
    end

    // stage 5 norm
    logic                          v5_reg;
    ivg_pkg::sq_t                  sq_reg;
    ivg_pkg::sq_t                  sq_next;

    always_comb
    begin
        sq_next.tag = tag4_reg;
        sq_next.rem = sqx_reg + sqy_reg + sqz_reg;
        sq_next.res = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2v_reg <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
        end
        else if (en)
        begin
            v1_reg  <= in_valid;
            v2v_reg <= v1_reg;
            v3_reg  <= v2v_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg    <= $signed({1'b0, de});
            v0_reg   <= v0;
            v1v_reg  <= v1;
            v2_reg   <= v2;
            c1_reg   <= c1;
            c2_reg   <= c2;
            row_reg  <= grid_row;
            dq_reg   <= dq;
            cs_reg   <= cs;
            a0x_reg  <= a0x_next;
            a0y_reg  <= a0y_next;
            a0z_reg  <= a0z_next;
            a1x_reg  <= a1x_next;
            a1y_reg  <= a1y_next;
            a1z_reg  <= a1z_next;
            a2x_reg  <= a2x_next;
            a2y_reg  <= a2y_next;
            a2z_reg  <= a2z_next;
            idx2_reg <= idx_next;
            tag3_reg <= tag3_next;
            tag4_reg <= tag3_reg;
            sqx_reg  <= ivg_pkg::NW'(sqx_next);
            sqy_reg  <= ivg_pkg::NW'(sqy_next);
            sqz_reg  <= ivg_pkg::NW'(sqz_next);
            sq_reg   <= sq_next;
        end
    end

    assign sq_valid = v5_reg;
    assign sq_item  = sq_reg;

endmodule

/* rtl/core/ivg_sqrt.sv */
// pipelined integer square root, one result bit per stage
module ivg_sqrt (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  ivg_pkg::sq_t  in_item,
    output logic          out_valid,
    output ivg_pkg::sq_t  out_item
);

    localparam int N = ivg_pkg::SQ_STAGES;

    ivg_pkg::sq_t  stage_in [N];
    ivg_pkg::sq_t  sq_next  [N];
    ivg_pkg::sq_t  sq_reg   [N];
    logic [N-1:0]  vld_reg;

    always_comb
    begin
        stage_in[0] = in_item;
        for (int k = 1; k < N; k++)
            stage_in[k] = sq_reg[k-1];
    end

    always_comb
    begin
        logic [ivg_pkg::NW-1:0] bitv;
        logic [ivg_pkg::NW-1:0] trial;
        for (int k = 0; k < N; k++)
        begin
            bitv  = ivg_pkg::NW'(1) << (ivg_pkg::NW - 2 - 2 * k);
            trial = stage_in[k].res + bitv;
            sq_next[k] = stage_in[k];
            if (stage_in[k].rem >= trial)
            begin
                sq_next[k].rem = stage_in[k].rem - trial;
                sq_next[k].res = (stage_in[k].res >> 1) + bitv;
            end
            else
            begin
                sq_next[k].res = stage_in[k].res >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[N-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
                sq_reg[k] <= sq_next[k];
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_item  = sq_reg[N-1];

endmodule

/* rtl/core/ivg_div.sv */
// pipelined restoring divide of each coordinate by the length, plus output register
module ivg_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  ivg_pkg::sq_t                       in_item,
    output logic                               out_valid,
    output logic [ivg_pkg::IDXW-1:0]           vertex_index,
    output logic signed [ivg_pkg::OW-1:0]      pos_x,
    output logic signed [ivg_pkg::OW-1:0]      pos_y,
    output logic signed [ivg_pkg::OW-1:0]      pos_z
);

    localparam int N = ivg_pkg::QW;

    // prep: magnitudes, rounding offset
    ivg_pkg::dv_t  prep_next;

    always_comb
    begin
        logic signed [ivg_pkg::PW-1:0] p [3];
        logic [ivg_pkg::PW-1:0]        mag;
        logic [ivg_pkg::SW-1:0]        s;
        p[0] = in_item.tag.px;
        p[1] = in_item.tag.py;
        p[2] = in_item.tag.pz;
        s = in_item.res[ivg_pkg::SW-1:0];
        prep_next.idx  = in_item.tag.idx;
        prep_next.s    = s;
        prep_next.zero = (s == '0);
        for (int c = 0; c < 3; c++)
        begin
            mag = p[c][ivg_pkg::PW-1] ? ivg_pkg::PW'(-p[c]) : ivg_pkg::PW'(p[c]);
            prep_next.neg[c] = p[c][ivg_pkg::PW-1];
            prep_next.num[c] = {1'b0, mag, ivg_pkg::FRAC'(0)}
                             + {ivg_pkg::FRAC'(0), 1'b0, 1'b0, s[ivg_pkg::SW-1:1]};
            prep_next.q[c]   = '0;
        end
    end

    ivg_pkg::dv_t  stage_in [N];
    ivg_pkg::dv_t  dv_next  [N];
    ivg_pkg::dv_t  dv_reg   [N];
    ivg_pkg::dv_t  prep_reg;
    logic          prep_vld_reg;
    logic [N-1:0]  vld_reg;

    always_comb
    begin
        stage_in[0] = prep_reg;
        for (int k = 1; k < N; k++)
            stage_in[k] = dv_reg[k-1];
    end

    always_comb
    begin
        logic [ivg_pkg::DNW-1:0] trial;
        for (int k = 0; k < N; k++)
        begin
            dv_next[k] = stage_in[k];
            trial = {ivg_pkg::QW'(0), stage_in[k].s} << (N - 1 - k);
            for (int c = 0; c < 3; c++)
            begin
                if (stage_in[k].num[c] >= trial)
                begin
                    dv_next[k].num[c]        = stage_in[k].num[c] - trial;
                    dv_next[k].q[c][N-1-k]   = 1'b1;
                end
            end
        end
    end

    // output: saturate, sign, zero length
    logic signed [ivg_pkg::OW-1:0] pos_next [3];
    ivg_pkg::dv_t                  last;

    always_comb
    begin
        logic [ivg_pkg::OW-1:0] qs;
        last = dv_reg[N-1];
        for (int c = 0; c < 3; c++)
        begin
            qs = {1'b0, last.q[c]};
            if (qs > ivg_pkg::OW'(ivg_pkg::OUT_ONE))
                qs = ivg_pkg::OW'(ivg_pkg::OUT_ONE);
            if (last.zero)
                pos_next[c] = '0;
            else if (last.neg[c])
                pos_next[c] = -$signed(qs);
            else
                pos_next[c] = $signed(qs);
        end
    end

    logic out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_vld_reg <= 1'b0;
            vld_reg      <= '0;
            out_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            prep_vld_reg <= in_valid;
            vld_reg      <= {vld_reg[N-2:0], prep_vld_reg};
            out_vld_reg  <= vld_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_reg <= prep_next;
            for (int k = 0; k < N; k++)
                dv_reg[k] <= dv_next[k];
            vertex_index <= last.idx;
            pos_x        <= pos_next[0];
            pos_y        <= pos_next[1];
            pos_z        <= pos_next[2];
        end
    end

    assign out_valid = out_vld_reg;

endmodule

/* rtl/core/icosphere_vertex_generator_top.sv */
// icosphere vertex generator top level
// each request passes through the front, square root and divide stages in that order to become a result
// throughput: one request per cycle; every stage moves together unless the result is stalled
// a stalled result holds the whole pipeline and raises in_stall in the same cycle
// reset: asynchronous active low, clears all valid bits and sets detail_reg to 1
module icosphere_vertex_generator_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               detail_we,
    input  logic [ivg_pkg::DW-1:0]             detail_level,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [2:0]                         strip_sel,
    input  logic [6:0]                         grid_column,
    input  logic [7:0]                         grid_row,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [ivg_pkg::IDXW-1:0]           vertex_index,
    output logic signed [ivg_pkg::OW-1:0]      pos_x,
    output logic signed [ivg_pkg::OW-1:0]      pos_y,
    output logic signed [ivg_pkg::OW-1:0]      pos_z
);

    logic [ivg_pkg::DW-1:0] detail_reg;
    logic                   en;
    logic                   sq_valid;
    ivg_pkg::sq_t           sq_item;
    logic                   rt_valid;
    ivg_pkg::sq_t           rt_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            detail_reg <= ivg_pkg::DW'(1);
        else if (detail_we)
            detail_reg <= detail_level;
    end

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    ivg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .detail      (detail_reg),
        .in_valid    (in_valid),
        .strip_sel   (strip_sel),
        .grid_column (grid_column),
        .grid_row    (grid_row),
        .sq_valid    (sq_valid),
        .sq_item     (sq_item)
    );

    ivg_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_item   (sq_item),
        .out_valid (rt_valid),
        .out_item  (rt_item)
    );

    ivg_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (rt_valid),
        .in_item      (rt_item),
        .out_valid    (out_valid),
        .vertex_index (vertex_index),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z)
    );

endmodule

/* rtl/core/ivg_checker.sv */
// port-level checks for the icosphere vertex generator, bound to the top level
module ivg_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               detail_we,
    input  logic [ivg_pkg::DW-1:0]             detail_level,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [2:0]                         strip_sel,
    input  logic [6:0]                         grid_column,
    input  logic [7:0]                         grid_row,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [ivg_pkg::IDXW-1:0]           vertex_index,
    input  logic signed [ivg_pkg::OW-1:0]      pos_x,
    input  logic signed [ivg_pkg::OW-1:0]      pos_y,
    input  logic signed [ivg_pkg::OW-1:0]      pos_z
);

    localparam logic signed [ivg_pkg::OW-1:0] ONE  = ivg_pkg::OW'(ivg_pkg::OUT_ONE);
    localparam logic signed [ivg_pkg::OW-1:0] MONE = -ivg_pkg::OW'(ivg_pkg::OUT_ONE);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(vertex_index)
            && $stable(pos_x) && $stable(pos_y) && $stable(pos_z))
        else $error("stalled result changed");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pos_x <= ONE && pos_x >= MONE && pos_y <= ONE && pos_y >= MONE
            && pos_z <= ONE && pos_z >= MONE)
        else $error("coordinate out of unit range");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    a_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid right after reset");

endmodule

bind icosphere_vertex_generator_top ivg_checker u_chk (.*);
